// ===== rtl/core/fog_state_selector_unit_assert.svh =====
// Assertion macros for the fog state selector RTL.
`ifndef FOG_STATE_SELECTOR_UNIT_ASSERT_SVH
`define FOG_STATE_SELECTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FSS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fog state selector check failed");
`define FSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fog state selector check failed");
`else
`define FSS_ASSERT_NOW(label, clk, rstn, ante, cons)
`define FSS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/fss_pkg.sv =====
// Types, constants and register indexes of the fog state selector.
`default_nettype none
package fss_pkg;

    localparam int unsigned LIGHT_W    = 8;
    localparam int unsigned COLOR_W    = 24;
    localparam int unsigned BASE_W     = 8;
    localparam int unsigned DEN_W      = 9;
    localparam int unsigned PROD_W     = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // Density curve knees and fixed values.
    localparam logic [LIGHT_W-1:0] CURVE_KNEE      = 8'd164;
    localparam logic [LIGHT_W-1:0] CURVE_END       = 8'd230;
    localparam logic [BASE_W-1:0]  DEFAULT_DENSITY = 8'd70;
    localparam logic [BASE_W-1:0]  MIN_INV_LIGHT   = 8'd30;
    localparam logic [COLOR_W-1:0] GREY_COLOR      = 24'h808080;

    // Reciprocals for the two constant divisions of the curve. Both are
    // rounded up and exact over the numerator ranges that can occur.
    localparam int unsigned KNEE_SHIFT = 23;
    localparam int unsigned KNEE_DIV   = 164;
    localparam logic [15:0] KNEE_RECIP =
        16'(((1 << KNEE_SHIFT) + KNEE_DIV - 1) / KNEE_DIV);
    localparam int unsigned SPAN_SHIFT = 20;
    localparam int unsigned SPAN_DIV   = 66;
    localparam logic [13:0] SPAN_RECIP =
        14'(((1 << SPAN_SHIFT) + SPAN_DIV - 1) / SPAN_DIV);

    // Queue between the classifier and the command stage.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DENSITY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_COLOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_DEFINED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_DENSITY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_TABLE_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_FOG_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_COLORMAP   = 3'd6;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_DISABLE = 2'd1,
        ACT_ENABLE  = 2'd2
    } action_t;

    // How the second front stage finishes the density.
    typedef enum logic [1:0] {
        CURVE_NONE = 2'd0,
        CURVE_LOW  = 2'd1,
        CURVE_HIGH = 2'd2
    } curve_t;

    typedef struct packed {
        logic [BASE_W-1:0]  level_density;
        logic [COLOR_W-1:0] outside_color;
        logic               outside_defined;
        logic [BASE_W-1:0]  outside_density;
        logic               fade_table_mode;
        logic               depth_fog_enable;
        logic               fixed_colormap;
    } cfg_t;

    // Register values after reset: depth fog on, everything else clear.
    localparam cfg_t CFG_RESET = '{
        level_density:    '0,
        outside_color:    '0,
        outside_defined:  1'b0,
        outside_density:  '0,
        fade_table_mode:  1'b0,
        depth_fog_enable: 1'b1,
        fixed_colormap:   1'b0
    };

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [DEN_W-1:0]   density;
    } item_t;

endpackage
`default_nettype wire

// ===== rtl/core/fog_state_selector_unit.sv =====
// Top level of the fog state selector: configuration registers and datapath.
`default_nettype none
`include "fog_state_selector_unit_assert.svh"

// The fog state selector takes one polygon beat per clock on the s_ channel
// while s_ready is high (light level, fog colour, additive-blend and skybox
// flags) and returns exactly one command beat per polygon on the m_ channel,
// in order. Each result says whether fog must be disabled or enabled and
// whether a new colour or a new integer density must be written; the block
// keeps the last colour and density it sent and only asks for a write when
// the value changes. Sustained throughput is one beat per cycle while
// m_ready stays high. A beat passes three registers: the classifier
// register, which also forms the light curve product and is loaded at the
// edge that accepts the beat, the two-entry queue, and the command output
// register, which presents its result. The classifier keeps accepting while
// a result waits for m_ready; it only stalls once its own register, the
// queue and the output register are all full. The seven fog registers are
// written through cfg_we, cfg_index and cfg_wdata, take effect on the next
// beat and must only be changed while no beat is in flight. Indexes beyond
// the register list are ignored. After reset fog is enabled by register, no
// colour or density is cached, and the first beat that needs fog reports an
// enable.
module fog_state_selector_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [fss_pkg::LIGHT_W-1:0]    s_light_level,
    input  wire logic [fss_pkg::COLOR_W-1:0]    s_fog_color,
    input  wire logic                           s_additive_blend,
    input  wire logic                           s_in_skybox,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [1:0]                          m_fog_action,
    output logic                                m_color_write,
    output logic [fss_pkg::COLOR_W-1:0]         m_color_value,
    output logic                                m_density_write,
    output logic [fss_pkg::DEN_W-1:0]          m_density_value
);

    // Configuration registers. Depth fog is on after reset; the rest clear.
    fss_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                fss_pkg::REG_LEVEL_DENSITY:
                    cfg_next.level_density = cfg_wdata[fss_pkg::BASE_W-1:0];
                fss_pkg::REG_OUTSIDE_COLOR:
                    cfg_next.outside_color = cfg_wdata[fss_pkg::COLOR_W-1:0];
                fss_pkg::REG_OUTSIDE_DEFINED:
                    cfg_next.outside_defined = cfg_wdata[0];
                fss_pkg::REG_OUTSIDE_DENSITY:
                    cfg_next.outside_density = cfg_wdata[fss_pkg::BASE_W-1:0];
                fss_pkg::REG_FADE_TABLE_MODE:
                    cfg_next.fade_table_mode = cfg_wdata[0];
                fss_pkg::REG_DEPTH_FOG_ENABLE:
                    cfg_next.depth_fog_enable = cfg_wdata[0];
                fss_pkg::REG_FIXED_COLORMAP:
                    cfg_next.fixed_colormap = cfg_wdata[0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= fss_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The classifier hands finished colour and density pairs to the queue.
    logic           q_valid;
    logic           q_ready;
    fss_pkg::item_t q_item;
    logic           b_valid;
    logic           b_ready;
    fss_pkg::item_t b_item;

    fss_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_light_level    (s_light_level),
        .s_fog_color      (s_fog_color),
        .s_additive_blend (s_additive_blend),
        .s_in_skybox      (s_in_skybox),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item)
    );

    fss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    // The command stage owns the colour and density cache.
    fss_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .depth_fog_enable (cfg_reg.depth_fog_enable),
        .in_valid         (b_valid),
        .in_ready         (b_ready),
        .in_item          (b_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_fog_action     (m_fog_action),
        .m_color_write    (m_color_write),
        .m_color_value    (m_color_value),
        .m_density_write  (m_density_write),
        .m_density_value  (m_density_value)
    );

    // A disable command never comes with a colour or density write.
    `FSS_ASSERT_NOW(a_disable_no_write, aclk, aresetn, m_valid && (m_fog_action == fss_pkg::ACT_DISABLE), !m_color_write && !m_density_write)
    // Both caches are dropped together, so an enable always rewrites both.
    `FSS_ASSERT_NOW(a_enable_writes_both, aclk, aresetn, m_valid && (m_fog_action == fss_pkg::ACT_ENABLE), m_color_write && m_density_write)
    // A density of zero must turn into a disable, never into a write.
    `FSS_ASSERT_NOW(a_density_write_nonzero, aclk, aresetn, m_valid && m_density_write, m_density_value != '0)
    // Every accepted polygon is offered to the queue on the next cycle.
    `FSS_ASSERT_NEXT(a_accept_reaches_queue, aclk, aresetn, s_valid && s_ready, q_valid)

endmodule
`default_nettype wire

// ===== rtl/core/fss_front.sv =====
// Front end: classifies each polygon and works out its fog colour and density.
`default_nettype none
module fss_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire fss_pkg::cfg_t                cfg,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [fss_pkg::LIGHT_W-1:0]  s_light_level,
    input  wire logic [fss_pkg::COLOR_W-1:0]  s_fog_color,
    input  wire logic                         s_additive_blend,
    input  wire logic                         s_in_skybox,
    output logic                              q_valid,
    input  wire logic                         q_ready,
    output fss_pkg::item_t                    q_item
);

    logic                         s1_valid_reg, s1_valid_next;
    fss_pkg::curve_t              s1_curve_reg, s1_curve_next;
    logic [fss_pkg::BASE_W-1:0]   s1_base_reg, s1_base_next;
    logic [fss_pkg::PROD_W-1:0]   s1_prod_reg, s1_prod_next;
    logic [fss_pkg::COLOR_W-1:0]  s1_color_reg, s1_color_next;
    logic                         s1_skybox_reg, s1_skybox_next;

    logic [fss_pkg::BASE_W-1:0]   d_base;
    logic [fss_pkg::BASE_W-1:0]   half_base;
    logic [fss_pkg::BASE_W-1:0]   outside_base;
    logic [fss_pkg::BASE_W-1:0]   inv_light;
    logic [fss_pkg::BASE_W-1:0]   mul_a, mul_b;
    logic                         accept;

    logic [31:0]                  knee_full;
    logic [27:0]                  span_full;
    logic [fss_pkg::BASE_W-1:0]   knee_quot;
    logic [fss_pkg::BASE_W-1:0]   span_quot;
    logic [fss_pkg::BASE_W-1:0]   d8;
    logic [fss_pkg::DEN_W-1:0]    density;

    assign s_ready = !s1_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;

    // Stage one: pick the density source and start the curve product.
    always_comb begin
        d_base       = (cfg.level_density != '0) ? cfg.level_density
                                                 : fss_pkg::DEFAULT_DENSITY;
        half_base    = d_base >> 1;
        outside_base = ((cfg.outside_density != '0) ? cfg.outside_density : d_base) >> 1;
        inv_light    = ~s_light_level;
        mul_a        = '0;
        mul_b        = '0;
        s1_curve_next = fss_pkg::CURVE_NONE;
        s1_base_next  = '0;

        if (cfg.fade_table_mode) begin
            s1_base_next = fss_pkg::DEFAULT_DENSITY;
        end else if (cfg.fixed_colormap) begin
            s1_base_next = '0;
        end else if (s_fog_color == '0) begin
            if (s_light_level < fss_pkg::CURVE_KNEE) begin
                s1_curve_next = fss_pkg::CURVE_LOW;
                s1_base_next  = half_base;
                mul_a         = d_base;
                mul_b         = fss_pkg::CURVE_KNEE - s_light_level;
            end else if (s_light_level < fss_pkg::CURVE_END) begin
                s1_curve_next = fss_pkg::CURVE_HIGH;
                s1_base_next  = half_base;
                mul_a         = half_base;
                mul_b         = s_light_level - fss_pkg::CURVE_KNEE;
            end else begin
                s1_base_next = '0;
            end
        end else if (cfg.outside_defined && (s_fog_color == cfg.outside_color)) begin
            s1_base_next = outside_base;
        end else if ((cfg.level_density >> 1) != '0) begin
            s1_base_next = cfg.level_density >> 1;
        end else begin
            s1_base_next = (inv_light < fss_pkg::MIN_INV_LIGHT) ? fss_pkg::MIN_INV_LIGHT
                                                                : inv_light;
        end

        s1_prod_next   = fss_pkg::PROD_W'(mul_a) * fss_pkg::PROD_W'(mul_b);
        s1_color_next  = cfg.fade_table_mode ? fss_pkg::GREY_COLOR : s_fog_color;
        if (s_additive_blend) begin
            s1_color_next = '0;
        end
        s1_skybox_next = s_in_skybox;
        s1_valid_next  = s_ready ? s_valid : s1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_curve_reg  <= s1_curve_next;
            s1_base_reg   <= s1_base_next;
            s1_prod_reg   <= s1_prod_next;
            s1_color_reg  <= s1_color_next;
            s1_skybox_reg <= s1_skybox_next;
        end
    end

    // Stage two: constant divisions by reciprocal, curve finish, skybox boost.
    always_comb begin
        knee_full = {16'b0, s1_prod_reg} * {16'b0, fss_pkg::KNEE_RECIP};
        span_full = {14'b0, s1_prod_reg[13:0]} * {14'b0, fss_pkg::SPAN_RECIP};
        knee_quot = knee_full[fss_pkg::KNEE_SHIFT +: fss_pkg::BASE_W];
        span_quot = span_full[fss_pkg::SPAN_SHIFT +: fss_pkg::BASE_W];

        unique case (s1_curve_reg)
            fss_pkg::CURVE_LOW:  d8 = s1_base_reg + knee_quot;
            fss_pkg::CURVE_HIGH: d8 = s1_base_reg - span_quot;
            default:             d8 = s1_base_reg;
        endcase

        density = {1'b0, d8};
        if (s1_skybox_reg) begin
            density = {1'b0, d8} + {2'b0, d8[fss_pkg::BASE_W-1:1]};
        end
    end

    assign q_valid        = s1_valid_reg;
    assign q_item.color   = s1_color_reg;
    assign q_item.density = density;

endmodule
`default_nettype wire

// ===== rtl/core/fss_queue.sv =====
// Short queue that decouples the classifier from the command stage.
`default_nettype none
module fss_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire fss_pkg::item_t  in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output fss_pkg::item_t       out_item
);

    fss_pkg::item_t                 entry_reg [fss_pkg::QUEUE_DEPTH];
    logic [fss_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [fss_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [fss_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           push, pop;

    assign in_ready  = (count_reg != fss_pkg::QCNT_W'(fss_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == fss_pkg::QPTR_W'(fss_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == fss_pkg::QPTR_W'(fss_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/fss_back.sv =====
// Back end: compares against the cached fog state and issues the commands.
`default_nettype none
module fss_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        depth_fog_enable,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire fss_pkg::item_t              in_item,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [1:0]                       m_fog_action,
    output logic                             m_color_write,
    output logic [fss_pkg::COLOR_W-1:0]      m_color_value,
    output logic                             m_density_write,
    output logic [fss_pkg::DEN_W-1:0]        m_density_value
);

    logic                         m_valid_reg, m_valid_next;
    fss_pkg::action_t             action_reg, action_next;
    logic                         cw_reg, cw_next;
    logic [fss_pkg::COLOR_W-1:0]  cv_reg, cv_next;
    logic                         dw_reg, dw_next;
    logic [fss_pkg::DEN_W-1:0]    dv_reg, dv_next;

    logic                         color_valid_reg, color_valid_next;
    logic [fss_pkg::COLOR_W-1:0]  color_reg, color_next;
    logic                         den_valid_reg, den_valid_next;
    logic [fss_pkg::DEN_W-1:0]    den_reg, den_next;

    logic                         pop;
    logic                         fog_off;
    logic                         color_diff;
    logic                         den_diff;

    assign in_ready = !m_valid_reg || m_ready;
    assign pop      = in_valid && in_ready;

    always_comb begin
        fog_off    = (in_item.density == '0) || !depth_fog_enable;
        color_diff = !color_valid_reg || (color_reg != in_item.color);
        den_diff   = !den_valid_reg || (den_reg != in_item.density);

        action_next      = fss_pkg::ACT_NONE;
        cw_next          = 1'b0;
        cv_next          = '0;
        dw_next          = 1'b0;
        dv_next          = '0;
        color_valid_next = color_valid_reg;
        color_next       = color_reg;
        den_valid_next   = den_valid_reg;
        den_next         = den_reg;

        if (fog_off) begin
            action_next      = fss_pkg::ACT_DISABLE;
            color_valid_next = 1'b0;
            den_valid_next   = 1'b0;
        end else begin
            if (color_diff) begin
                if (!color_valid_reg) begin
                    action_next = fss_pkg::ACT_ENABLE;
                end
                cw_next          = 1'b1;
                cv_next          = in_item.color;
                color_next       = in_item.color;
                color_valid_next = 1'b1;
            end
            if (den_diff) begin
                dw_next        = 1'b1;
                dv_next        = in_item.density;
                den_next       = in_item.density;
                den_valid_next = 1'b1;
            end
        end

        m_valid_next = in_ready ? in_valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            color_valid_reg <= 1'b0;
            den_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                color_valid_reg <= color_valid_next;
                den_valid_reg   <= den_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            action_reg <= action_next;
            cw_reg     <= cw_next;
            cv_reg     <= cv_next;
            dw_reg     <= dw_next;
            dv_reg     <= dv_next;
            color_reg  <= color_next;
            den_reg    <= den_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_fog_action    = action_reg;
    assign m_color_write   = cw_reg;
    assign m_color_value   = cv_reg;
    assign m_density_write = dw_reg;
    assign m_density_value = dv_reg;

endmodule
`default_nettype wire
